>>> rtl/core/qie_pkg.sv
package qie_pkg;

    localparam int MAX_LOG_SIDE = 7;
    localparam int LS_W         = 3;
    localparam int LV_W         = $clog2(MAX_LOG_SIDE + 1);
    localparam int CRD_W        = MAX_LOG_SIDE;
    localparam int PYR_DEPTH    = ((1 << (2 * (MAX_LOG_SIDE + 1))) - 1) / 3;
    localparam int ADDR_W       = $clog2(PYR_DEPTH);
    localparam int CNT_W        = 2 * MAX_LOG_SIDE + 1;

    localparam logic [1:0] CODE_MIXED = 2'd2;
    localparam logic [1:0] SYM_OPEN   = 2'd2;
    localparam logic [1:0] SYM_CLOSE  = 2'd3;

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_NODE  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic action;
        logic pixel;
    } in_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last;
        logic       empty_res;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       fetch_rd;
        logic [1:0] child;
        logic       cap;
        logic [1:0] cap_idx;
        logic       par_wr;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic image_full;
        logic multi;
        logic build_last;
    } stat_t;

    // First pyramid entry of the level whose blocks have side 2^lv.
    function automatic logic [ADDR_W-1:0] level_base(input logic [LV_W-1:0] lv);
        logic [ADDR_W-1:0] b;
        b = '0;
        for (int l = 0; l < MAX_LOG_SIDE; l++) begin
            if (l < int'(lv))
            begin
                b = b + ADDR_W'(1 << (2 * (MAX_LOG_SIDE - l)));
            end
        end
        return b;
    endfunction

endpackage

>>> rtl/core/quadtree_image_encoder_unit.sv
// Channel  | Ports                      | Transfer
// ---------+----------------------------+-------------------------------
// input    | start, busy, item          | edge with start high, busy low
// result   | strobe, result             | edge ending the strobe cycle
// config   | cfg_we, cfg_data           | edge with cfg_we high
//
// A load writes its pixel on the transfer edge; a fetch goes through the registered
// read of the block-code memory, with the result shown from that register in S_OUT.
// The last pixel starts a pyramid build that reads the four children and writes the code
// of each upper-level block, (4^n - 1) / 3 blocks for side 2^n, during which busy stays high.
// Reset clears the control state only; the memory is filled by loading.
// The receiver cannot stall, so results never wait.
module quadtree_image_encoder_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  qie_pkg::in_t             item,
    input  logic                     cfg_we,
    input  logic [qie_pkg::LS_W-1:0] cfg_data,
    output logic                     strobe,
    output qie_pkg::out_t            result
);
    import qie_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    qie_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    qie_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    assign strobe = cmd.emit;

`ifndef SYNTH
    a_fetch_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.action == ACT_FETCH |=> strobe)
        else $error("fetch transfer without a result");

    a_result_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && item.action == ACT_FETCH))
        else $error("result without a fetch");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.empty_res |-> result.symbol == 2'd0 && !result.last)
        else $error("empty result carries a symbol");
`endif

endmodule

>>> rtl/core/qie_ctrl.sv
module qie_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    input  qie_pkg::stat_t stat,
    output logic          busy,
    output qie_pkg::cmd_t cmd
);
    import qie_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_FETCH)
                    begin
                        cmd.fetch_rd = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (stat.image_full && stat.multi)
                        begin
                            state_next = S_RD0;
                        end
                    end
                end
            end
            S_RD0:
            begin
                cmd.child  = 2'd0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.child   = 2'd1;
                cmd.cap     = 1'b1;
                cmd.cap_idx = 2'd0;
                state_next  = S_RD2;
            end
            S_RD2:
            begin
                cmd.child   = 2'd2;
                cmd.cap     = 1'b1;
                cmd.cap_idx = 2'd1;
                state_next  = S_RD3;
            end
            S_RD3:
            begin
                cmd.child   = 2'd3;
                cmd.cap     = 1'b1;
                cmd.cap_idx = 2'd2;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.par_wr = 1'b1;
                state_next = stat.build_last ? S_IDLE : S_RD0;
            end
            S_OUT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/qie_dpath.sv
module qie_dpath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qie_pkg::in_t             item,
    input  logic                     cfg_we,
    input  logic [qie_pkg::LS_W-1:0] cfg_data,
    input  qie_pkg::cmd_t            cmd,
    output qie_pkg::stat_t           stat,
    output qie_pkg::out_t            result
);
    import qie_pkg::*;

    logic [1:0] mem [PYR_DEPTH];
    logic [1:0] rd_reg;
    logic [1:0] ch_reg [3];

    logic [LS_W-1:0]  log_side_reg, log_side_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       path_reg [MAX_LOG_SIDE+1];
    logic [1:0]       path_next [MAX_LOG_SIDE+1];
    logic [LV_W-1:0]  level_reg, level_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LV_W-1:0]  blv_reg, blv_next;
    logic [CRD_W-1:0] bx_reg, bx_next, by_reg, by_next;

    logic [LV_W-1:0]   n;
    logic [CNT_W-1:0]  total;
    logic              restart;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LV_W-1:0]   lv;
    logic [CRD_W-1:0]  x, y;
    logic [ADDR_W-1:0] faddr, caddr, paddr, waddr, raddr;
    logic [LV_W-1:0]   bsh;
    logic [CRD_W-1:0]  smax;
    logic [1:0]        code, wdata;
    logic              same, we;
    logic [LV_W-1:0]   d;

    assign n       = (int'(log_side_reg) > MAX_LOG_SIDE) ? LV_W'(MAX_LOG_SIDE)
                                                         : LV_W'(log_side_reg);
    assign total   = CNT_W'(1) << (2 * n);
    assign restart = (phase_reg != PH_LOAD);
    assign cnt_eff = restart ? '0 : count_reg;
    assign cnt_inc = cnt_eff + CNT_W'(1);
    assign d       = level_reg;
    assign lv      = n - d;

    always_comb
    begin
        x = '0;
        y = '0;
        for (int i = 0; i < MAX_LOG_SIDE; i++) begin
            if (i < int'(d))
            begin
                if (path_reg[i] == 2'd0 || path_reg[i] == 2'd3)
                begin
                    x[int'(n) - 1 - i] = 1'b1;
                end
                if (path_reg[i] == 2'd2 || path_reg[i] == 2'd3)
                begin
                    y[int'(n) - 1 - i] = 1'b1;
                end
            end
        end
    end

    assign faddr = level_base(lv) + (ADDR_W'(y >> lv) << d) + ADDR_W'(x >> lv);

    assign bsh   = n - blv_reg;
    assign smax  = (CRD_W'(1) << bsh) - CRD_W'(1);
    assign caddr = level_base(blv_reg - LV_W'(1))
                 + (ADDR_W'(by_reg) << (bsh + LV_W'(2)))
                 + (ADDR_W'(bx_reg) << 1)
                 + (cmd.child[1] ? (ADDR_W'(1) << (bsh + LV_W'(1))) : '0)
                 + ADDR_W'(cmd.child[0]);
    assign paddr = level_base(blv_reg) + (ADDR_W'(by_reg) << bsh) + ADDR_W'(bx_reg);

    assign same  = (ch_reg[0] != CODE_MIXED) && (ch_reg[1] == ch_reg[0])
                && (ch_reg[2] == ch_reg[0]) && (rd_reg == ch_reg[0]);
    assign code  = same ? ch_reg[0] : CODE_MIXED;

    assign we    = cmd.load | cmd.par_wr;
    assign waddr = cmd.load ? ADDR_W'(cnt_eff[2*MAX_LOG_SIDE-1:0]) : paddr;
    assign wdata = cmd.load ? {1'b0, item.pixel} : code;
    assign raddr = cmd.fetch_rd ? faddr : caddr;

    assign stat.image_full = (cnt_inc == total);
    assign stat.multi      = (n != '0);
    assign stat.build_last = (bx_reg == smax) && (by_reg == smax) && (blv_reg == n);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
        if (cmd.cap)
        begin
            ch_reg[cmd.cap_idx] <= rd_reg;
        end
    end

    always_comb
    begin
        log_side_next = log_side_reg;
        count_next    = count_reg;
        path_next     = path_reg;
        level_next    = level_reg;
        phase_next    = phase_reg;
        blv_next      = blv_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        result        = '0;

        if (cfg_we)
        begin
            log_side_next = cfg_data;
            count_next    = '0;
            level_next    = '0;
            phase_next    = PH_LOAD;
            for (int i = 0; i <= MAX_LOG_SIDE; i++) begin
                path_next[i] = 2'd0;
            end
        end

        if (cmd.load)
        begin
            if (restart)
            begin
                for (int i = 0; i <= MAX_LOG_SIDE; i++) begin
                    path_next[i] = 2'd0;
                end
            end
            count_next = cnt_inc;
            level_next = '0;
            phase_next = stat.image_full ? PH_NODE : PH_LOAD;
            blv_next   = LV_W'(1);
            bx_next    = '0;
            by_next    = '0;
        end

        if (cmd.par_wr)
        begin
            if (bx_reg == smax)
            begin
                bx_next = '0;
                if (by_reg == smax)
                begin
                    by_next  = '0;
                    blv_next = blv_reg + LV_W'(1);
                end
                else
                begin
                    by_next = by_reg + CRD_W'(1);
                end
            end
            else
            begin
                bx_next = bx_reg + CRD_W'(1);
            end
        end

        if (cmd.emit)
        begin
            if (phase_reg == PH_LOAD || phase_reg == PH_DONE)
            begin
                result.empty_res = 1'b1;
            end
            else if (phase_reg == PH_NODE && rd_reg == CODE_MIXED)
            begin
                result.symbol = SYM_OPEN;
                path_next[d]  = 2'd0;
                level_next    = d + LV_W'(1);
            end
            else
            begin
                result.symbol = (phase_reg == PH_CLOSE) ? SYM_CLOSE : {1'b0, rd_reg[0]};
                // Step past the finished node.
                if (d == '0)
                begin
                    phase_next  = PH_DONE;
                    result.last = 1'b1;
                end
                else if (path_reg[d - LV_W'(1)] != 2'd3)
                begin
                    path_next[d - LV_W'(1)] = path_reg[d - LV_W'(1)] + 2'd1;
                    phase_next              = PH_NODE;
                end
                else
                begin
                    level_next = d - LV_W'(1);
                    phase_next = PH_CLOSE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_side_reg <= LS_W'(7);
            count_reg    <= '0;
            level_reg    <= '0;
            phase_reg    <= PH_LOAD;
            blv_reg      <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            for (int i = 0; i <= MAX_LOG_SIDE; i++) begin
                path_reg[i] <= 2'd0;
            end
        end
        else
        begin
            log_side_reg <= log_side_next;
            count_reg    <= count_next;
            level_reg    <= level_next;
            phase_reg    <= phase_next;
            blv_reg      <= blv_next;
            bx_reg       <= bx_next;
            by_reg       <= by_next;
            path_reg     <= path_next;
        end
    end

endmodule
